[rtl/mdts_pkg.sv]
// Package for the map drum trigger sequencer: transfer structs, codes,
// sequencer states and fixed constants. No dependencies.

package mdts_pkg;

	// Fixed sizes
	localparam int STEPS_DEFAULT = 32;
	localparam int NODE_COUNT    = 25;
	localparam int PART_COUNT    = 3;
	localparam int LEN_W         = 6;   // euclidean length 1..32
	localparam int REM_DW        = 10;  // widest remainder dividend

	localparam logic [31:0] NOISE_SEED         = 32'hA17C9E31;
	localparam logic [7:0]  ACCENT_LEVEL       = 8'd192;
	localparam logic [7:0]  EUCLID_ACCENT_FILL = 8'd184;

	// Operation codes
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_STEP  = 2'd1,
		OP_PULSE = 2'd2,
		OP_RESET = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic CFG_EUCLID = 1'b0;
	localparam logic CFG_RES    = 1'b1;

	// Clock resolution codes
	localparam logic [1:0] RES_4 = 2'd0;
	localparam logic [1:0] RES_8 = 2'd1;

	typedef struct packed {
		op_t        operation;
		logic [7:0] map_x;
		logic [7:0] map_y;
		logic [7:0] chaos;
		logic [7:0] fill_kick;
		logic [7:0] fill_snare;
		logic [7:0] fill_hat;
		logic [4:0] load_node;
		logic [1:0] load_part;
		logic [4:0] load_step;
		logic [7:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic       step_fired;
		logic [4:0] step_number;
		logic       kick_hit;
		logic       snare_hit;
		logic       hat_hit;
		logic       kick_accent;
		logic       snare_accent;
		logic       hat_accent;
		logic       beat_mark;
		logic       hat_pan_right;
	} out_item_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PERT,
		ST_PART,
		ST_RD,
		ST_MIX,
		ST_EVAL,
		ST_EMUL,
		ST_EDIV,
		ST_EREM1,
		ST_EMUL2,
		ST_EREM2,
		ST_FINISH
	} state_t;

endpackage

[rtl/mdts_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.

module mdts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2400
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[rtl/mdts_rem.sv]
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on mdts_pkg.

module mdts_rem
	import mdts_pkg::*;
#(
	parameter int DW = REM_DW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW-1:0]    dividend,
	input  logic [LEN_W-1:0] divisor,
	output logic             done,
	output logic [LEN_W-1:0] remainder
);

	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]    dvd_q;
	logic [LEN_W-1:0] div_q;
	logic [LEN_W-1:0] rem_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W:0]   trial;
	logic [LEN_W-1:0] nrem;

	// One shift-compare-subtract step
	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		if (trial >= {1'b0, div_q}) begin
			nrem = LEN_W'(trial - {1'b0, div_q});
		end else begin
			nrem = LEN_W'(trial);
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNTW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= nrem;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

[rtl/map_drum_trigger_sequencer_unit.sv]
// Three-part drum trigger generator: map interpolation or euclidean mode.
// Depends on mdts_pkg, mdts_ram, mdts_rem.
//
// Usage: items arrive on in_valid/in_stall/in_data, one result per item
// leaves on out_valid/out_stall/out_data. Configuration writes use
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// A load item writes one map byte. A map-mode step reads, per part, the four
// nodes on the single registered RAM port and makes 3 passes through the
// shared bilinear mix unit. A euclidean step makes two passes of the
// bit-serial remainder unit per part. Either step runs a noise refresh first
// at step 0. A reset item runs the noise refresh and finishes. Non-firing
// items go straight to the finishing state.
// in_stall is high while an item is being worked on. The result sits in an
// output register; the next item is accepted while it waits, and its own
// result waits in the finishing state until the register is taken.
// Reset clears the step and subpulse counters, the perturbation amounts and
// the configuration, and loads the noise seed. The map memory is not
// cleared: entries read before being written hold arbitrary data.

module map_drum_trigger_sequencer_unit
	import mdts_pkg::*;
#(
	parameter int STEPS_PER_PATTERN = STEPS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [1:0] cfg_data
);

	localparam int CW    = $clog2(STEPS_PER_PATTERN);
	localparam int DEPTH = NODE_COUNT * PART_COUNT * STEPS_PER_PATTERN;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [CW:0]   STEPS_W = (CW + 1)'(STEPS_PER_PATTERN);
	localparam logic [6:0]    STEPS_7 = 7'(STEPS_PER_PATTERN);
	localparam logic [AW-1:0] STEPS_A = AW'(STEPS_PER_PATTERN);

	state_t state_q, state_d;

	logic          in_accept;
	logic          out_free;
	in_item_t      item_q;
	logic [CW-1:0] step_cnt_q;
	logic [1:0]    sub_q;
	logic [CW-1:0] step_q;
	logic          fire_q;
	logic          op3_q;
	logic          euclid_q;
	logic [1:0]    res_q;
	logic [1:0]    part_q;
	logic [2:0]    k_q;
	logic [31:0]   noise_q;
	logic [7:0]    perturb_q [PART_COUNT];
	logic [7:0]    nodes_q [4];
	logic [7:0]    mix_q [3];
	logic [2:0]    hits_q;
	logic [2:0]    acc_q;
	logic [13:0]   prod_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] pulses_q;
	logic [LEN_W-1:0] m_q;
	out_item_t     out_q;
	logic          out_valid_q;

	// Handshake
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Step advance for the accepted item
	logic       fire_now;
	logic [1:0] adv;
	logic [1:0] nsub;
	logic [3:0] sub_sum;
	logic [3:0] inc;
	logic [CW:0] cnt_sum;
	logic [CW-1:0] cnt_next;

	always_comb begin
		case (res_q)
			RES_4:   inc = 4'd6;
			RES_8:   inc = 4'd3;
			default: inc = 4'd1;
		endcase
		sub_sum = {2'b00, sub_q} + inc;
		if (sub_sum >= 4'd6) begin
			adv  = 2'd2;
			nsub = 2'(sub_sum - 4'd6);
		end else if (sub_sum >= 4'd3) begin
			adv  = 2'd1;
			nsub = 2'(sub_sum - 4'd3);
		end else begin
			adv  = 2'd0;
			nsub = 2'(sub_sum);
		end
		if (in_data.operation == OP_PULSE) begin
			cnt_sum = {1'b0, step_cnt_q} + (CW + 1)'(adv);
		end else begin
			cnt_sum = {1'b0, step_cnt_q} + (CW + 1)'(1);
		end
		if (cnt_sum >= STEPS_W) begin
			cnt_next = CW'(cnt_sum - STEPS_W);
		end else begin
			cnt_next = CW'(cnt_sum);
		end
		fire_now = (in_data.operation == OP_STEP) ||
			((in_data.operation == OP_PULSE) && (sub_q == 2'd0));
	end

	// Map write address
	logic [6:0]    lstep;
	logic [6:0]    wrow;
	logic [AW-1:0] waddr;
	logic          wvalid;

	always_comb begin
		lstep = {2'b00, in_data.load_step};
		for (int i = 0; i < 3; i++) begin
			if (lstep >= STEPS_7) begin
				lstep = lstep - STEPS_7;
			end
		end
		wrow   = 7'(in_data.load_node) * 7'd3 + 7'(in_data.load_part);
		waddr  = AW'(wrow) * STEPS_A + AW'(lstep);
		wvalid = (in_data.load_node < 5'(NODE_COUNT)) &&
			(in_data.load_part < 2'(PART_COUNT));
	end

	// Map read address for node k of the current cell
	logic [4:0]    ii, jj, rnode;
	logic [6:0]    rrow;
	logic [AW-1:0] raddr;

	always_comb begin
		ii    = {3'b000, item_q.map_x[7:6]} + {4'b0000, k_q[0]};
		jj    = {3'b000, item_q.map_y[7:6]} + {4'b0000, k_q[1]};
		rnode = ii * 5'd5 + jj;
		rrow  = 7'(rnode) * 7'd3 + 7'(part_q);
		raddr = AW'(rrow) * STEPS_A + AW'(step_q);
	end

	// Map memory
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_rdata;

	mdts_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(in_data.load_value),
		.rdata(ram_rdata)
	);

	// Remainder unit
	logic              rem_start;
	logic [REM_DW-1:0] rem_dividend;
	logic              rem_done;
	logic [LEN_W-1:0]  rem_out;

	mdts_rem #(
		.DW(REM_DW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dividend),
		.divisor  (len_q),
		.done     (rem_done),
		.remainder(rem_out)
	);

	// Per-part controls
	logic [7:0] fill_p, src_p;

	always_comb begin
		case (part_q)
			2'd0: begin
				fill_p = item_q.fill_kick;
				src_p  = item_q.map_x;
			end
			2'd1: begin
				fill_p = item_q.fill_snare;
				src_p  = item_q.map_y;
			end
			default: begin
				fill_p = item_q.fill_hat;
				src_p  = item_q.chaos;
			end
		endcase
	end

	// Noise generator and perturbation scaling
	logic [31:0] ns1, ns2, ns3;
	logic [13:0] pert_prod;

	always_comb begin
		ns1       = noise_q ^ (noise_q << 13);
		ns2       = ns1 ^ (ns1 >> 17);
		ns3       = ns2 ^ (ns2 << 5);
		pert_prod = 14'(ns3[31:24]) * 14'(item_q.chaos[7:2]);
	end

	// Shared bilinear mix unit
	logic [7:0]  ma, mb, mf;
	logic [7:0]  mdiff;
	logic [16:0] mprod;
	logic [8:0]  mres;
	logic [7:0]  mix_out;

	always_comb begin
		case (k_q)
			3'd0: begin
				ma = nodes_q[0];
				mb = nodes_q[1];
				mf = {item_q.map_x[5:0], 2'b00};
			end
			3'd1: begin
				ma = nodes_q[2];
				mb = nodes_q[3];
				mf = {item_q.map_x[5:0], 2'b00};
			end
			default: begin
				ma = mix_q[0];
				mb = mix_q[1];
				mf = {item_q.map_y[5:0], 2'b00};
			end
		endcase
		if (mb >= ma) begin
			mdiff = mb - ma;
			mprod = 17'(mdiff) * 17'(mf);
			mres  = {1'b0, ma} + 9'(mprod[16:8]);
		end else begin
			mdiff = ma - mb;
			mprod = 17'(mdiff) * 17'(mf) + 17'd255;
			mres  = {1'b0, ma} - 9'(mprod[16:8]);
		end
		mix_out = mres[8] ? 8'hFF : mres[7:0];
	end

	// Level threshold
	logic [8:0] lvl_sum;
	logic [7:0] lvl;

	always_comb begin
		lvl_sum = {1'b0, mix_q[2]} + {1'b0, perturb_q[part_q]};
		lvl     = lvl_sum[8] ? 8'hFF : lvl_sum[7:0];
	end

	// Euclidean pulse count: round(fill*len/255) by reciprocal and correction
	logic [14:0] en;
	logic [22:0] en257;
	logic [LEN_W-1:0] qe;
	logic [14:0] q510;
	logic [14:0] erem;
	logic [LEN_W-1:0] pulses_d;
	logic        ehit;

	always_comb begin
		en    = {prod_q, 1'b0} + 15'd255;
		en257 = {en, 8'h00} + 23'(en);
		qe    = LEN_W'(en257[22:17]);
		q510  = {qe, 9'h000} - {8'h00, qe, 1'b0};
		erem  = en - q510;
		pulses_d = (erem >= 15'd510) ? qe + 1'b1 : qe;
		ehit  = (pulses_q != '0) &&
			((pulses_q >= len_q) || (rem_out < pulses_q));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					case (in_data.operation)
						OP_LOAD:  state_d = ST_FINISH;
						OP_RESET: state_d = ST_PERT;
						OP_STEP, OP_PULSE: begin
							if (!fire_now) begin
								state_d = ST_FINISH;
							end else if (step_cnt_q == '0) begin
								state_d = ST_PERT;
							end else begin
								state_d = ST_PART;
							end
						end
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_PERT: begin
				if (k_q == 3'd2) begin
					state_d = op3_q ? ST_FINISH : ST_PART;
				end
			end
			ST_PART:  state_d = euclid_q ? ST_EMUL : ST_RD;
			ST_RD:    if (k_q == 3'd4) state_d = ST_MIX;
			ST_MIX:   if (k_q == 3'd2) state_d = ST_EVAL;
			ST_EVAL:  state_d = (part_q == 2'd2) ? ST_FINISH : ST_PART;
			ST_EMUL:  state_d = ST_EDIV;
			ST_EDIV:  state_d = ST_EREM1;
			ST_EREM1: if (rem_done) state_d = ST_EMUL2;
			ST_EMUL2: state_d = ST_EREM2;
			ST_EREM2: begin
				if (rem_done) begin
					state_d = (part_q == 2'd2) ? ST_FINISH : ST_PART;
				end
			end
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall     = 1'b1;
		ram_we       = 1'b0;
		ram_addr     = raddr;
		rem_start    = 1'b0;
		rem_dividend = REM_DW'(step_q);
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ram_addr = waddr;
				ram_we   = in_accept && (in_data.operation == OP_LOAD) && wvalid;
			end
			ST_EDIV: begin
				rem_start = 1'b1;
			end
			ST_EMUL2: begin
				rem_start    = 1'b1;
				rem_dividend = REM_DW'(m_q) * REM_DW'(pulses_q);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// State register and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_cnt_q  <= '0;
			sub_q       <= '0;
			euclid_q    <= 1'b0;
			res_q       <= RES_4;
			noise_q     <= NOISE_SEED;
			perturb_q   <= '{default: 8'h00};
			out_valid_q <= 1'b0;
			k_q         <= '0;
			part_q      <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= (state_d != state_q) ? 3'd0 : k_q + 1'b1;
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_EUCLID: euclid_q <= cfg_data[0];
					CFG_RES:    res_q    <= cfg_data;
					default:    res_q    <= res_q;
				endcase
			end
			// step counters move at accept; the latched step is evaluated
			if (in_accept) begin
				part_q <= '0;
				case (in_data.operation)
					OP_STEP:  step_cnt_q <= cnt_next;
					OP_PULSE: begin
						step_cnt_q <= cnt_next;
						sub_q      <= nsub;
					end
					OP_RESET: begin
						step_cnt_q <= '0;
						sub_q      <= '0;
					end
					default: step_cnt_q <= step_cnt_q;
				endcase
			end
			if ((state_q == ST_EVAL) ||
				((state_q == ST_EREM2) && rem_done)) begin
				part_q <= part_q + 1'b1;
			end
			// perturbation refresh
			if (state_q == ST_PERT) begin
				noise_q <= ns3;
				perturb_q[2'(k_q)] <= 8'(pert_prod[13:8]);
			end
			// output register
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_q <= in_data;
			step_q <= step_cnt_q;
			fire_q <= fire_now;
			op3_q  <= (in_data.operation == OP_RESET);
			hits_q <= '0;
			acc_q  <= '0;
		end
		if (state_q == ST_RD && k_q != 3'd0) begin
			nodes_q[2'(k_q - 3'd1)] <= ram_rdata;
		end
		if (state_q == ST_MIX) begin
			mix_q[2'(k_q)] <= mix_out;
		end
		if (state_q == ST_EVAL) begin
			hits_q[part_q] <= lvl > ~fill_p;
			acc_q[part_q]  <= lvl > ACCENT_LEVEL;
		end
		if (state_q == ST_EMUL) begin
			len_q  <= LEN_W'(src_p[7:3]) + 1'b1;
			prod_q <= 14'(fill_p) * 14'(LEN_W'(src_p[7:3]) + 1'b1);
		end
		if (state_q == ST_EDIV) begin
			pulses_q <= pulses_d;
		end
		if (state_q == ST_EREM1 && rem_done) begin
			m_q <= rem_out;
		end
		if (state_q == ST_EREM2 && rem_done) begin
			hits_q[part_q] <= ehit;
			acc_q[part_q]  <= fill_p >= EUCLID_ACCENT_FILL;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q.step_fired    <= fire_q;
			out_q.step_number   <= fire_q ? 5'(step_q) : 5'd0;
			out_q.kick_hit      <= hits_q[0];
			out_q.snare_hit     <= hits_q[1];
			out_q.hat_hit       <= hits_q[2];
			out_q.kick_accent   <= hits_q[0] && acc_q[0];
			out_q.snare_accent  <= hits_q[1] && acc_q[1];
			out_q.hat_accent    <= hits_q[2] && acc_q[2];
			out_q.beat_mark     <= (fire_q && (step_q[2:0] == 3'd0)) || op3_q;
			out_q.hat_pan_right <= fire_q && hits_q[2] && step_q[2];
		end
	end

	// Assertions
	a_we_at_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE && in_accept))
		else $error("map write outside an accepted load");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not registered on finish");

	a_pert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PERT) |-> (k_q < 3'd3))
		else $error("perturbation refresh overran");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, step_cnt_q} < STEPS_W))
		else $error("step counter out of range");

endmodule

[tb/mdts_trigger_checker.sv]
// Checker for the map drum trigger sequencer: watches the item, result and
// register channels, predicts every result and compares it field by field.
// Depends on mdts_pkg.

module mdts_trigger_checker
	import mdts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  in_item_t   in_data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  out_item_t  out_data,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data,
	output int         pending,
	output int         failures,
	output int         checked
);

	localparam int STEPS = STEPS_DEFAULT;

	// Mirror of the sequencer state
	logic [7:0]  level_map [0:NODE_COUNT*PART_COUNT*STEPS-1];
	logic [4:0]  step_pos;
	int          subpulse;
	int          perturb [PART_COUNT];
	logic [31:0] noise;
	logic        euclid_on;
	logic [1:0]  resolution;

	out_item_t   trigger_q [$];

	// xorshift 13/17/5, top byte out
	function automatic int next_noise_byte();
		noise = noise ^ (noise << 13);
		noise = noise ^ (noise >> 17);
		noise = noise ^ (noise << 5);
		return int'(noise[31:24]);
	endfunction

	function automatic void refresh_perturb(logic [7:0] chaos);
		int amount;
		amount = chaos >> 2;
		for (int p = 0; p < PART_COUNT; p++) begin
			perturb[p] = (next_noise_byte() * amount) >> 8;
		end
	endfunction

	// Linear blend, rounded down and clamped to 255
	function automatic int blend(int a, int b, int f);
		int r;
		if (b >= a) begin
			r = a + (((b - a) * f) >> 8);
		end else begin
			r = a - ((((a - b) * f) + 255) >> 8);
		end
		return (r > 255) ? 255 : r;
	endfunction

	function automatic int map_level(int part, logic [7:0] x, logic [7:0] y);
		int i, j, fx, fy, a, b, c, d;
		i  = x >> 6;
		j  = y >> 6;
		fx = (x & 8'h3f) << 2;
		fy = (y & 8'h3f) << 2;
		a  = level_map[((i * 5 + j) * PART_COUNT + part) * STEPS + step_pos];
		b  = level_map[(((i + 1) * 5 + j) * PART_COUNT + part) * STEPS + step_pos];
		c  = level_map[((i * 5 + j + 1) * PART_COUNT + part) * STEPS + step_pos];
		d  = level_map[(((i + 1) * 5 + j + 1) * PART_COUNT + part) * STEPS + step_pos];
		return blend(blend(a, b, fx), blend(c, d, fx), fy);
	endfunction

	// Evaluate the current step for all three parts
	function automatic out_item_t evaluate_step(in_item_t it);
		out_item_t o;
		int src [PART_COUNT];
		int fill [PART_COUNT];
		bit hit [PART_COUNT];
		bit acc [PART_COUNT];
		int len, pulses, lvl;
		src[0]  = it.map_x;
		src[1]  = it.map_y;
		src[2]  = it.chaos;
		fill[0] = it.fill_kick;
		fill[1] = it.fill_snare;
		fill[2] = it.fill_hat;
		if (step_pos == 0) refresh_perturb(it.chaos);
		for (int p = 0; p < PART_COUNT; p++) begin
			if (euclid_on) begin
				len    = 1 + (src[p] >> 3);
				pulses = (fill[p] * len * 2 + 255) / 510;
				if (pulses == 0) hit[p] = 0;
				else if (pulses >= len) hit[p] = 1;
				else hit[p] = (((step_pos % len) * pulses) % len) < pulses;
				acc[p] = fill[p] >= EUCLID_ACCENT_FILL;
			end else begin
				lvl = map_level(p, it.map_x, it.map_y) + perturb[p];
				if (lvl > 255) lvl = 255;
				hit[p] = lvl > 255 - fill[p];
				acc[p] = lvl > ACCENT_LEVEL;
			end
		end
		o               = '0;
		o.step_fired    = 1'b1;
		o.step_number   = step_pos;
		o.beat_mark     = step_pos[2:0] == 3'd0;
		o.kick_hit      = hit[0];
		o.snare_hit     = hit[1];
		o.hat_hit       = hit[2];
		o.kick_accent   = hit[0] && acc[0];
		o.snare_accent  = hit[1] && acc[1];
		o.hat_accent    = hit[2] && acc[2];
		o.hat_pan_right = hit[2] && step_pos[2];
		return o;
	endfunction

	// Apply one accepted item to the mirror and return its result
	function automatic out_item_t predict_trigger(in_item_t it);
		out_item_t o;
		int inc, sub;
		o = '0;
		case (it.operation)
			OP_LOAD: begin
				if (it.load_node < NODE_COUNT && it.load_part < PART_COUNT)
					level_map[(it.load_node * PART_COUNT + it.load_part) * STEPS
						+ it.load_step] = it.load_value;
			end
			OP_STEP: begin
				o = evaluate_step(it);
				step_pos = step_pos + 5'd1;
			end
			OP_PULSE: begin
				if (resolution == RES_4) inc = 6;
				else if (resolution == RES_8) inc = 3;
				else inc = 1;
				if (subpulse == 0) o = evaluate_step(it);
				sub = subpulse + inc;
				while (sub >= 3) begin
					sub = sub - 3;
					step_pos = step_pos + 5'd1;
				end
				subpulse = sub;
			end
			default: begin
				step_pos = '0;
				subpulse = 0;
				refresh_perturb(it.chaos);
				o.beat_mark = 1'b1;
			end
		endcase
		return o;
	endfunction

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			failures++;
		end
	endfunction

	// Track transfers on all three channels
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			step_pos   = '0;
			subpulse   = 0;
			noise      = NOISE_SEED;
			euclid_on  = 1'b0;
			resolution = '0;
			for (int p = 0; p < PART_COUNT; p++) perturb[p] = 0;
			trigger_q.delete();
			pending  = 0;
			failures = 0;
			checked  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_EUCLID) euclid_on = cfg_data[0];
				else resolution = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (trigger_q.size() == 0) begin
					$error("result transfer with no expectation waiting");
					failures++;
				end else begin
					e = trigger_q.pop_front();
					checked++;
					check_field("step_fired", e.step_fired, out_data.step_fired);
					check_field("step_number", e.step_number, out_data.step_number);
					check_field("kick_hit", e.kick_hit, out_data.kick_hit);
					check_field("snare_hit", e.snare_hit, out_data.snare_hit);
					check_field("hat_hit", e.hat_hit, out_data.hat_hit);
					check_field("kick_accent", e.kick_accent, out_data.kick_accent);
					check_field("snare_accent", e.snare_accent, out_data.snare_accent);
					check_field("hat_accent", e.hat_accent, out_data.hat_accent);
					check_field("beat_mark", e.beat_mark, out_data.beat_mark);
					check_field("hat_pan_right", e.hat_pan_right, out_data.hat_pan_right);
				end
			end
			if (in_valid && !in_stall) trigger_q.push_back(predict_trigger(in_data));
			pending = trigger_q.size();
		end
	end

endmodule

[tb/tb_map_drum_trigger_sequencer_unit.sv]
// Testbench top for the map drum trigger sequencer: clock, reset, stimulus,
// register writes, result-side stalls and the verdict.
// Depends on mdts_pkg, map_drum_trigger_sequencer_unit, mdts_trigger_checker.

module tb_map_drum_trigger_sequencer_unit
	import mdts_pkg::*;
;

	localparam int IDLE_LIMIT = 20000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [1:0] cfg_data;

	int pending, failures, checked;
	int items_sent;
	int settings_used;
	int idle_cycles;
	bit burst_mode;
	bit euclid_set;
	int stall_hold;

	map_drum_trigger_sequencer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mdts_trigger_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.failures  (failures),
		.checked   (checked)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (burst_mode) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Byte biased towards the extremes
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'd0;
		if (r == 1) return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	// Map position: in map mode kept inside the loaded upper corner cell
	function automatic logic [7:0] pick_pos();
		int r;
		if (euclid_set) return pick_byte();
		r = $urandom_range(0, 9);
		if (r == 0) return 8'd192;
		if (r == 1) return 8'd255;
		return 8'($urandom_range(192, 255));
	endfunction

	function automatic in_item_t make_item(op_t op);
		in_item_t    it;
		logic [95:0] raw;
		raw           = {$urandom, $urandom, $urandom};
		it            = raw[$bits(in_item_t)-1:0];
		it.operation  = op;
		it.map_x      = pick_pos();
		it.map_y      = pick_pos();
		it.chaos      = pick_byte();
		it.fill_kick  = pick_byte();
		it.fill_snare = pick_byte();
		it.fill_hat   = pick_byte();
		return it;
	endfunction

	function automatic in_item_t random_item();
		int r;
		in_item_t it;
		r = $urandom_range(0, 99);
		if (r < 15) it = make_item(OP_LOAD);
		else if (r < 60) it = make_item(OP_STEP);
		else if (r < 95) it = make_item(OP_PULSE);
		else it = make_item(OP_RESET);
		if ($urandom_range(0, 9) != 0) it.load_node = 5'($urandom_range(0, NODE_COUNT - 1));
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
	endtask

	task automatic send_step(op_t op, logic [7:0] x, logic [7:0] y, logic [7:0] ch,
			logic [7:0] fill);
		in_item_t it;
		it            = make_item(op);
		it.map_x      = x;
		it.map_y      = y;
		it.chaos      = ch;
		it.fill_kick  = fill;
		it.fill_snare = fill;
		it.fill_hat   = fill;
		send_item(it);
	endtask

	// Register write once the block has drained
	task automatic write_reg(logic idx, logic [1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(logic euclid, logic [1:0] res);
		write_reg(CFG_EUCLID, {1'b0, euclid});
		write_reg(CFG_RES, res);
		euclid_set = euclid;
		settings_used++;
	endtask

	// Result side stalls: random runs, some long, some stall-free stretches
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			case ($urandom_range(0, 9))
				0:       begin out_stall <= 1'b1; stall_hold <= $urandom_range(10, 40); end
				1, 2:    begin out_stall <= 1'b1; stall_hold <= $urandom_range(0, 3); end
				3:       begin out_stall <= 1'b0; stall_hold <= $urandom_range(50, 200); end
				default: begin out_stall <= 1'b0; stall_hold <= $urandom_range(0, 5); end
			endcase
		end
	end

	// Watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		in_valid      = 1'b0;
		in_data       = '0;
		out_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = 1'b0;
		cfg_data      = '0;
		stall_hold    = 0;
		idle_cycles   = 0;
		items_sent    = 0;
		settings_used = 0;
		burst_mode    = 0;
		euclid_set    = 0;
		arst_n        = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the four nodes of the upper corner cell; map-mode positions stay inside it
		for (int nx = 3; nx < 5; nx++)
			for (int ny = 3; ny < 5; ny++)
				for (int p = 0; p < PART_COUNT; p++)
					for (int s = 0; s < STEPS_DEFAULT; s++) begin
						it            = make_item(OP_LOAD);
						it.load_node  = 5'(nx * 5 + ny);
						it.load_part  = 2'(p);
						it.load_step  = 5'(s);
						it.load_value = ($urandom_range(0, 7) == 0) ? 8'd255 : pick_byte();
						send_item(it);
					end

		// Map mode corners, pulses, reset, ignored loads
		set_mode(1'b0, 2'd0);
		send_step(OP_STEP, 8'd192, 8'd192, 8'd0, 8'd0);
		send_step(OP_STEP, 8'd255, 8'd255, 8'd255, 8'd255);
		send_step(OP_STEP, 8'd200, 8'd250, 8'd128, 8'd200);
		send_step(OP_PULSE, 8'd255, 8'd192, 8'd255, 8'd128);
		send_step(OP_PULSE, 8'd192, 8'd255, 8'd0, 8'd255);
		send_step(OP_RESET, 8'd192, 8'd192, 8'd255, 8'd0);
		send_step(OP_STEP, 8'd224, 8'd208, 8'd255, 8'd64);
		it = make_item(OP_LOAD);
		it.load_node = 5'd31;
		send_item(it);
		it = make_item(OP_LOAD);
		it.load_part = 2'd3;
		send_item(it);

		// Euclidean lengths and densities at their edges
		set_mode(1'b1, 2'd3);
		send_step(OP_STEP, 8'd0, 8'd0, 8'd0, 8'd0);
		send_step(OP_STEP, 8'd255, 8'd255, 8'd255, 8'd255);
		send_step(OP_STEP, 8'd255, 8'd100, 8'd7, 8'd184);
		send_step(OP_STEP, 8'd255, 8'd8, 8'd200, 8'd183);
		for (int k = 0; k < 6; k++) send_step(OP_PULSE, 8'd255, 8'd40, 8'd90, 8'd130);
		send_step(OP_RESET, 8'd0, 8'd0, 8'd0, 8'd0);

		// Random phases across register settings
		for (int ph = 0; ph < 8; ph++) begin
			set_mode(1'(ph % 2 == 1), 2'((ph / 2) % 4));
			for (int k = 0; k < 65; k++) send_item(random_item());
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("Sent %0d items over %0d register settings, %0d results checked",
			items_sent, settings_used, checked);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[files.f]
rtl/mdts_pkg.sv
rtl/mdts_ram.sv
rtl/mdts_rem.sv
rtl/map_drum_trigger_sequencer_unit.sv
tb/mdts_trigger_checker.sv
tb/tb_map_drum_trigger_sequencer_unit.sv
